FILE: rtl/core/running_mean_stddev_harmonic_assert.svh
// Assertion macros shared by the running statistics RTL.
`ifndef RUNNING_MEAN_STDDEV_HARMONIC_ASSERT_SVH
`define RUNNING_MEAN_STDDEV_HARMONIC_ASSERT_SVH

// Same-cycle implication, disabled while reset is asserted.
`define RMSH_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define RMSH_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: rtl/core/rmsh_pkg.sv
// Package with widths, register indexes and helpers for the running statistics block.
package rmsh_pkg;

  localparam int COUNT_BITS_DEF  = 24;
  localparam int SAMPLE_BITS_DEF = 16;

  localparam int SAMPLE_W = 16;
  localparam int COUNT_W  = 24;
  localparam int STAT_W   = 32;
  localparam int CFG_IDX_W = 2;
  localparam int CFG_DATA_W = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_START_COUNT     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_START_MEAN      = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_START_HARMONIC  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_START_DEVIATION = 2'd3;

  localparam logic OP_RESTART = 1'b0;
  localparam logic OP_SAMPLE  = 1'b1;

  function automatic logic [63:0] sat_add64(input logic [63:0] a, input logic [63:0] b);
    logic [64:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[64] ? '1 : s[63:0];
  endfunction

  function automatic logic [STAT_W-1:0] clip32(input logic [63:0] v);
    return (v[63:32] != '0) ? '1 : v[31:0];
  endfunction

endpackage

FILE: rtl/core/rmsh_if.sv
// Valid/ready stream interfaces for the sample and result channels.
interface rmsh_in_if import rmsh_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                op;
  logic [SAMPLE_W-1:0] sample;
  modport source (output valid, output op, output sample, input ready);
  modport sink (input valid, input op, input sample, output ready);
endinterface

interface rmsh_out_if import rmsh_pkg::*; ();
  logic               valid;
  logic               ready;
  logic [COUNT_W-1:0] count;
  logic [STAT_W-1:0]  mean;
  logic [STAT_W-1:0]  deviation;
  logic [STAT_W-1:0]  harmonic;
  logic               zero_seen;
  modport source (output valid, output count, output mean, output deviation,
                  output harmonic, output zero_seen, input ready);
  modport sink (input valid, input count, input mean, input deviation,
                input harmonic, input zero_seen, output ready);
endinterface

FILE: rtl/core/rmsh_div.sv
// Restoring divider of a 128-bit dividend by a 64-bit divisor, one quotient bit per cycle.
module rmsh_div import rmsh_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  input  logic [63:0] hi,
  input  logic [63:0] lo,
  input  logic [63:0] den,
  output logic        busy,
  output logic        done,
  output logic [63:0] quot
);

  logic        busy_r, done_r;
  logic [63:0] rem_r, lo_r, q_r, den_r;
  logic [5:0]  cnt_r;
  logic [63:0] shifted;
  logic        take;

  assign shifted = {rem_r[62:0], lo_r[63]};
  assign take    = rem_r[63] || (shifted >= den_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        if (den == '0 || hi >= den) begin
          done_r <= 1'b1;
        end else begin
          busy_r <= 1'b1;
        end
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= hi;
      lo_r  <= lo;
      den_r <= den;
      cnt_r <= 6'd63;
      q_r   <= (den == '0 || hi >= den) ? '1 : '0;
    end else if (busy_r) begin
      rem_r <= take ? shifted - den_r : shifted;
      lo_r  <= {lo_r[62:0], 1'b0};
      q_r   <= {q_r[62:0], take};
      cnt_r <= cnt_r - 6'd1;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign quot = q_r;

endmodule

FILE: rtl/core/rmsh_sqrt.sv
// Bit-serial floor square root of a 64-bit value, one result bit per cycle.
module rmsh_sqrt import rmsh_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [63:0]       rad,
  output logic              busy,
  output logic              done,
  output logic [STAT_W-1:0] root
);

  logic        busy_r, done_r;
  logic [63:0] n_r, r_r, bit_r;
  logic [4:0]  cnt_r;
  logic [63:0] trial;
  logic        fits;

  assign trial = r_r + bit_r;
  assign fits  = n_r >= trial;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
      end else if (busy_r && cnt_r == '0) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      n_r   <= rad;
      r_r   <= '0;
      bit_r <= 64'h4000_0000_0000_0000;
      cnt_r <= 5'd31;
    end else if (busy_r) begin
      n_r   <= fits ? n_r - trial : n_r;
      r_r   <= fits ? (r_r >> 1) + bit_r : (r_r >> 1);
      bit_r <= bit_r >> 2;
      cnt_r <= cnt_r - 5'd1;
    end
  end

  assign busy = busy_r;
  assign done = done_r;
  assign root = r_r[STAT_W-1:0];

endmodule

FILE: rtl/core/running_mean_stddev_harmonic.sv
// Running count, mean, standard deviation and harmonic mean over a sample stream.
// Each transfer on the input channel yields one result transfer. A restart item
// reloads the sums from the start registers; a sample item makes up to four
// passes through the shared bit-serial divider and one through the bit-serial
// square root. The input is ready only between items, while a finished result
// may still wait in the output register. One shared 32x32 multiplier forms all
// products.
module running_mean_stddev_harmonic import rmsh_pkg::*; #(
  parameter int COUNT_BITS  = COUNT_BITS_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  rmsh_in_if.sink               in_ch,
  rmsh_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

`include "running_mean_stddev_harmonic_assert.svh"

  localparam logic [63:0] CNT_MAX64 = (64'd1 << COUNT_BITS) - 64'd1;

  typedef enum logic [19:0] {
    ST_IDLE = 20'h00001, ST_SD_M = 20'h00002, ST_SD_D = 20'h00004,
    ST_SD_L = 20'h00008, ST_SD_H = 20'h00010, ST_SD_X = 20'h00020,
    ST_SD_V = 20'h00040, ST_SD_W = 20'h00080, ST_UP_A = 20'h00100,
    ST_UP_B = 20'h00200, ST_RC_W = 20'h00400, ST_MN_S = 20'h00800,
    ST_MN_W = 20'h01000, ST_VR_S = 20'h02000, ST_VR_W = 20'h04000,
    ST_RT_S = 20'h08000, ST_RT_W = 20'h10000, ST_HM_S = 20'h20000,
    ST_HM_W = 20'h40000, ST_FIN  = 20'h80000
  } state_t;

  state_t state_r, state_nxt;

  logic [15:0]             cfg_count_r;
  logic [STAT_W-1:0]       cfg_mean_r, cfg_harm_r, cfg_dev_r;
  logic [COUNT_BITS-1:0]   count_r;
  logic [63:0]             vsum_r, sq_r, recip_r, acc_r, mul_p_r;
  logic                    zero_r;
  logic [SAMPLE_BITS-1:0]  s_r;
  logic [STAT_W-1:0]       mean_r, dev_r, harm_r;

  logic                    out_valid_r, out_zero_r;
  logic [COUNT_W-1:0]      out_count_r;
  logic [STAT_W-1:0]       out_mean_r, out_dev_r, out_harm_r;

  logic [31:0]             mul_a, mul_b;
  logic                    div_start, div_busy, div_done;
  logic [63:0]             div_hi, div_lo, div_den, div_q;
  logic                    sq_start, sq_busy, sq_done;
  logic [STAT_W-1:0]       sq_root;

  logic [63:0]             n64, cnt64, s64, msq_diff;
  logic                    in_fire, out_load;

  assign n64      = 64'(cfg_count_r) & CNT_MAX64;
  assign cnt64    = 64'(count_r);
  assign s64      = 64'(s_r);
  assign in_fire  = in_ch.valid && (state_r == ST_IDLE);
  assign out_load = (state_r == ST_FIN) && (!out_valid_r || out_ch.ready);
  assign msq_diff = (div_q > mul_p_r) ? div_q - mul_p_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_count_r <= 16'd1;
      cfg_mean_r  <= 32'd65536;
      cfg_harm_r  <= 32'd65536;
      cfg_dev_r   <= 32'd65536;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_START_COUNT:     cfg_count_r <= cfg_wdata[15:0];
        CFG_START_MEAN:      cfg_mean_r  <= cfg_wdata;
        CFG_START_HARMONIC:  cfg_harm_r  <= cfg_wdata;
        CFG_START_DEVIATION: cfg_dev_r   <= cfg_wdata;
        default: ;
      endcase
    end
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      ST_SD_M: begin mul_a = cfg_mean_r; mul_b = cfg_mean_r; end
      ST_SD_D: begin mul_a = cfg_dev_r; mul_b = cfg_dev_r; end
      ST_SD_L: begin mul_a = n64[31:0]; mul_b = cfg_mean_r; end
      ST_SD_H: begin mul_a = n64[31:0]; mul_b = acc_r[31:0]; end
      ST_SD_X: begin mul_a = n64[31:0]; mul_b = acc_r[63:32]; end
      ST_UP_A: begin mul_a = s64[31:0]; mul_b = s64[31:0]; end
      ST_VR_S, ST_VR_W: begin mul_a = mean_r; mul_b = mean_r; end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    mul_p_r <= 64'(mul_a) * 64'(mul_b);
  end

  always_comb begin
    div_start = 1'b0;
    div_hi    = '0;
    div_lo    = '0;
    div_den   = '0;
    case (state_r)
      ST_SD_V: begin
        div_start = 1'b1;
        div_hi = n64 >> 8; div_lo = n64 << 56; div_den = 64'(cfg_harm_r);
      end
      ST_UP_B: begin
        div_start = (s_r != '0);
        div_lo = 64'd1 << 40; div_den = s64;
      end
      ST_MN_S: begin
        div_start = 1'b1;
        div_lo = vsum_r; div_den = cnt64;
      end
      ST_VR_S: begin
        div_start = 1'b1;
        div_hi = sq_r >> 40; div_lo = sq_r << 24; div_den = cnt64;
      end
      ST_HM_S: begin
        div_start = !zero_r;
        div_hi = cnt64 >> 8; div_lo = cnt64 << 56; div_den = recip_r;
      end
      default: ;
    endcase
  end

  assign sq_start = (state_r == ST_RT_S);

  rmsh_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_start), .hi(div_hi), .lo(div_lo),
    .den(div_den), .busy(div_busy), .done(div_done), .quot(div_q)
  );

  rmsh_sqrt u_sqrt (
    .clk(clk), .rst_n(rst_n), .start(sq_start), .rad(acc_r),
    .busy(sq_busy), .done(sq_done), .root(sq_root)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (in_fire) state_nxt = (in_ch.op == OP_RESTART) ? ST_SD_M : ST_UP_A;
      ST_SD_M: state_nxt = ST_SD_D;
      ST_SD_D: state_nxt = ST_SD_L;
      ST_SD_L: state_nxt = ST_SD_H;
      ST_SD_H: state_nxt = ST_SD_X;
      ST_SD_X: state_nxt = ST_SD_V;
      ST_SD_V: state_nxt = ST_SD_W;
      ST_SD_W: if (div_done) state_nxt = ST_FIN;
      ST_UP_A: state_nxt = ST_UP_B;
      ST_UP_B: state_nxt = (s_r == '0) ? ST_MN_S : ST_RC_W;
      ST_RC_W: if (div_done) state_nxt = ST_MN_S;
      ST_MN_S: state_nxt = ST_MN_W;
      ST_MN_W: if (div_done) state_nxt = ST_VR_S;
      ST_VR_S: state_nxt = ST_VR_W;
      ST_VR_W: if (div_done) state_nxt = ST_RT_S;
      ST_RT_S: state_nxt = ST_RT_W;
      ST_RT_W: if (sq_done) state_nxt = ST_HM_S;
      ST_HM_S: state_nxt = zero_r ? ST_FIN : ST_HM_W;
      ST_HM_W: if (div_done) state_nxt = ST_FIN;
      ST_FIN:  if (out_load) state_nxt = ST_IDLE;
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      count_r <= COUNT_BITS'(1);
      vsum_r  <= 64'd65536;
      sq_r    <= 64'd512;
      recip_r <= 64'd1 << 40;
      zero_r  <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        ST_SD_H: vsum_r <= mul_p_r;
        ST_SD_X: sq_r <= mul_p_r;
        ST_SD_V: begin
          sq_r    <= sq_r + (mul_p_r << 32);
          count_r <= n64[COUNT_BITS-1:0];
          zero_r  <= 1'b0;
        end
        ST_SD_W: if (div_done) recip_r <= div_q;
        ST_UP_A: begin
          if (cnt64 < CNT_MAX64) count_r <= count_r + COUNT_BITS'(1);
          vsum_r <= sat_add64(vsum_r, s64 << 16);
        end
        ST_UP_B: begin
          sq_r <= sat_add64(sq_r, mul_p_r << 8);
          if (s_r == '0) zero_r <= 1'b1;
        end
        ST_RC_W: if (div_done) recip_r <= sat_add64(recip_r, div_q);
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) s_r <= SAMPLE_BITS'(64'(in_ch.sample));
    case (state_r)
      ST_SD_D: acc_r <= mul_p_r;
      ST_SD_L: acc_r <= (acc_r >> 24) + (mul_p_r >> 24);
      ST_SD_W: begin
        mean_r <= cfg_mean_r;
        dev_r  <= cfg_dev_r;
        harm_r <= cfg_harm_r;
      end
      ST_MN_W: if (div_done) mean_r <= clip32(div_q);
      ST_VR_W: if (div_done) acc_r <= msq_diff;
      ST_RT_W: if (sq_done) dev_r <= sq_root;
      ST_HM_S: if (zero_r) harm_r <= '0;
      ST_HM_W: if (div_done) harm_r <= clip32(div_q);
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_count_r <= cnt64[COUNT_W-1:0];
      out_mean_r  <= mean_r;
      out_dev_r   <= dev_r;
      out_harm_r  <= harm_r;
      out_zero_r  <= zero_r;
    end
  end

  assign in_ch.ready      = (state_r == ST_IDLE);
  assign out_ch.valid     = out_valid_r;
  assign out_ch.count     = out_count_r;
  assign out_ch.mean      = out_mean_r;
  assign out_ch.deviation = out_dev_r;
  assign out_ch.harmonic  = out_harm_r;
  assign out_ch.zero_seen = out_zero_r;

  `RMSH_ASSERT_NOW(a_div_start_idle, div_start, !div_busy, "divider started while busy")
  `RMSH_ASSERT_NOW(a_sqrt_start_idle, sq_start, !sq_busy, "square root started while busy")
  `RMSH_ASSERT_NEXT(a_count_nonzero, state_r == ST_UP_A, count_r != '0, "count zero after sample")
  `RMSH_ASSERT_NEXT(a_zero_harm, out_load && zero_r, out_ch.harmonic == '0, "harmonic not zero after zero sample")

endmodule
